>>> rtl/core/pffl_pkg.sv
// Package for the physical frame free list unit: widths, command and
// register codes, datapath operation codes and the controller/datapath structs.
// No dependencies.
package pffl_pkg;

  // Frame numbers and command field
  localparam int unsigned FRAME_W = 10;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // Request command codes
  localparam logic [CMD_W-1:0] CMD_BUILD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_END   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STACK_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STACK_HIGH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP        = 2'd3;

  // Configuration reset values
  localparam logic [FRAME_W-1:0] HEAP_END_RST   = 10'd0;
  localparam logic [FRAME_W-1:0] STACK_LOW_RST  = 10'd1022;
  localparam logic [FRAME_W-1:0] STACK_HIGH_RST = 10'd1022;
  localparam logic [FRAME_W-1:0] TOP_RST        = 10'd1023;

  // Response status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  // Operations the controller asks of the datapath
  typedef enum logic [2:0] {
    DP_NONE,
    DP_BUILD_START,
    DP_BUILD_JUMP,
    DP_BUILD_APPEND,
    DP_ALLOC,
    DP_ALLOC_POP,
    DP_RELEASE,
    DP_NOP
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic list_empty;
    logic head_eq_tail;
    logic run1_more;
    logic run2_more;
    logic out_free;
  } dp_sts_t;

endpackage

>>> rtl/core/pffl_if.sv
// Channel interfaces of the physical frame free list unit: request,
// response and configuration write, each with valid/ready.
// Depends on pffl_pkg.
interface pffl_req_if;
  import pffl_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [FRAME_W-1:0] frame_in;

  modport source (output valid, command, frame_in, input ready);
  modport sink   (input valid, command, frame_in, output ready);
endinterface

interface pffl_rsp_if;
  import pffl_pkg::*;
  logic               valid;
  logic               ready;
  logic               status;
  logic [FRAME_W-1:0] frame_out;

  modport source (output valid, status, frame_out, input ready);
  modport sink   (input valid, status, frame_out, output ready);
endinterface

interface pffl_cfg_if;
  import pffl_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] addr;
  logic [FRAME_W-1:0]   wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface

>>> rtl/core/pffl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pffl_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/pffl_ctrl.sv
// Controller FSM of the frame free list: request handshake, build walk
// sequencing, allocate read wait and result hand-off.
// Depends on pffl_pkg.
module pffl_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_valid_i,
  input  logic [pffl_pkg::CMD_W-1:0] req_command_i,
  output logic                   req_ready_o,
  input  pffl_pkg::dp_sts_t      sts_i,
  output pffl_pkg::ctrl_cmd_t    cmd_o
);
  import pffl_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RUN1 = 3'd1;
  localparam logic [2:0] ST_RUN2 = 3'd2;
  localparam logic [2:0] ST_POP  = 3'd3;
  localparam logic [2:0] ST_RESP = 3'd4;

  logic [2:0] state_q, state_d;

  assign req_ready_o = (state_q == ST_IDLE);

  // Next state and datapath command
  always_comb begin
    state_d      = state_q;
    cmd_o.op       = DP_NONE;
    cmd_o.load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          unique case (req_command_i)
            CMD_BUILD: begin
              cmd_o.op = DP_BUILD_START;
              state_d  = ST_RUN1;
            end
            CMD_ALLOC: begin
              cmd_o.op = DP_ALLOC;
              // a pop that is not the last frame needs the link read
              state_d  = (!sts_i.list_empty && !sts_i.head_eq_tail) ? ST_POP : ST_RESP;
            end
            CMD_RELEASE: begin
              cmd_o.op = DP_RELEASE;
              state_d  = ST_RESP;
            end
            default: begin
              cmd_o.op = DP_NOP;
              state_d  = ST_RESP;
            end
          endcase
        end
      end
      // first run: heap end up to just below the stack
      ST_RUN1: begin
        if (sts_i.run1_more) begin
          cmd_o.op = DP_BUILD_APPEND;
        end else begin
          cmd_o.op = DP_BUILD_JUMP;
          state_d  = ST_RUN2;
        end
      end
      // second run: above the stack up to the top frame
      ST_RUN2: begin
        if (sts_i.run2_more) begin
          cmd_o.op = DP_BUILD_APPEND;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_POP: begin
        cmd_o.op = DP_ALLOC_POP;
        state_d  = ST_RESP;
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/pffl_dp.sv
// Datapath of the frame free list: config registers, head/tail/empty,
// build counter, next-link RAM, result and output registers.
// Depends on pffl_pkg and pffl_ram.
module pffl_dp #(
  parameter int unsigned NUM_FRAMES = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pffl_pkg::ctrl_cmd_t            cmd_i,
  output pffl_pkg::dp_sts_t              sts_o,
  input  logic [pffl_pkg::FRAME_W-1:0]   frame_in_i,
  input  logic                           cfg_we_i,
  input  logic [pffl_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [pffl_pkg::FRAME_W-1:0]   cfg_wdata_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           out_status_o,
  output logic [pffl_pkg::FRAME_W-1:0]   out_frame_o
);
  import pffl_pkg::*;

  localparam int unsigned AW = $clog2(NUM_FRAMES);

  // Configuration registers
  logic [FRAME_W-1:0] heap_end_q, stack_low_q, stack_high_q, top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_end_q   <= HEAP_END_RST;
      stack_low_q  <= STACK_LOW_RST;
      stack_high_q <= STACK_HIGH_RST;
      top_q        <= TOP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_HEAP_END:   heap_end_q   <= cfg_wdata_i;
        CFG_STACK_LOW:  stack_low_q  <= cfg_wdata_i;
        CFG_STACK_HIGH: stack_high_q <= cfg_wdata_i;
        CFG_TOP:        top_q        <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // List state, build counter, result
  logic [FRAME_W-1:0] head_q, head_d, tail_q, tail_d;
  logic               empty_q, empty_d;
  logic [FRAME_W:0]   cnt_q, cnt_d;
  logic               res_status_q, res_status_d;
  logic [FRAME_W-1:0] res_frame_q, res_frame_d;
  logic               out_valid_q;
  logic               out_status_q;
  logic [FRAME_W-1:0] out_frame_q;

  // RAM port signals
  logic               we, re;
  logic [FRAME_W-1:0] wdata, rdata;
  logic               tail_in_range, head_in_range;

  // frames at or above the table depth have no link entry
  assign tail_in_range = (32'(tail_q) < NUM_FRAMES);
  assign head_in_range = (32'(head_q) < NUM_FRAMES);

  assign sts_o.list_empty   = empty_q;
  assign sts_o.head_eq_tail = (head_q == tail_q);
  assign sts_o.run1_more    = (cnt_q < {1'b0, stack_low_q});
  assign sts_o.run2_more    = (cnt_q <= {1'b0, top_q});
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    empty_d      = empty_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_frame_d  = res_frame_q;
    we           = 1'b0;
    re           = 1'b0;
    wdata        = frame_in_i;
    unique case (cmd_i.op)
      DP_BUILD_START: begin
        head_d       = heap_end_q;
        tail_d       = heap_end_q;
        empty_d      = 1'b0;
        cnt_d        = {1'b0, heap_end_q} + (FRAME_W+1)'(1);
        res_status_d = STATUS_OK;
        res_frame_d  = '0;
      end
      DP_BUILD_JUMP: begin
        cnt_d = {1'b0, stack_high_q} + (FRAME_W+1)'(1);
      end
      // list is never empty while building
      DP_BUILD_APPEND: begin
        wdata  = cnt_q[FRAME_W-1:0];
        we     = tail_in_range;
        tail_d = cnt_q[FRAME_W-1:0];
        cnt_d  = cnt_q + (FRAME_W+1)'(1);
      end
      DP_ALLOC: begin
        if (empty_q) begin
          res_status_d = STATUS_EMPTY;
          res_frame_d  = '0;
        end else begin
          res_status_d = STATUS_OK;
          res_frame_d  = head_q;
          if (head_q == tail_q) begin
            empty_d = 1'b1;
          end else begin
            re = 1'b1;
          end
        end
      end
      DP_ALLOC_POP: begin
        head_d = head_in_range ? rdata : '0;
      end
      DP_RELEASE: begin
        res_status_d = STATUS_OK;
        res_frame_d  = '0;
        if (empty_q) begin
          head_d  = frame_in_i;
          tail_d  = frame_in_i;
          empty_d = 1'b0;
        end else begin
          we     = tail_in_range;
          tail_d = frame_in_i;
        end
      end
      DP_NOP: begin
        res_status_d = STATUS_OK;
        res_frame_d  = '0;
      end
      default: ;
    endcase
  end

  pffl_ram #(
    .WIDTH(FRAME_W),
    .DEPTH(NUM_FRAMES)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(AW'(tail_q)),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(AW'(head_q)),
    .rdata_o(rdata)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      empty_q     <= 1'b1;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
      cnt_q   <= cnt_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result and output payload
  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_frame_q  <= res_frame_d;
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_frame_q  <= res_frame_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_frame_o  = out_frame_q;

endmodule

>>> rtl/core/physical_frame_free_list_unit.sv
// Top level of the physical frame free list: FIFO frame allocator.
// Depends on pffl_pkg, pffl_if, pffl_ctrl, pffl_dp (and pffl_ram below it).
//
// Channel  Dir  Payload                      Transfer
// req_i    in   command[1:0], frame_in[9:0]  valid & ready
// rsp_o    out  status, frame_out[9:0]       valid & ready
// cfg_i    in   addr[1:0], wdata[9:0]        valid & ready (ready always high)
//
// Release and unused commands go from the request to the result register;
// allocate does too, and first reads the next link from the link RAM when it pops a frame that is not the last.
// Build walks one frame per cycle through both runs.
// One request is in flight at a time; the next is taken while the previous
// result still waits in the output register. No RAM clearing after reset.
module physical_frame_free_list_unit #(
  parameter int unsigned NUM_FRAMES = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pffl_req_if.sink   req_i,
  pffl_rsp_if.source rsp_o,
  pffl_cfg_if.sink   cfg_i
);
  import pffl_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  assign cfg_i.ready = 1'b1;

  pffl_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_command_i(req_i.command),
    .req_ready_o  (req_i.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  pffl_dp #(
    .NUM_FRAMES(NUM_FRAMES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .frame_in_i  (req_i.frame_in),
    .cfg_we_i    (cfg_i.valid),
    .cfg_addr_i  (cfg_i.addr),
    .cfg_wdata_i (cfg_i.wdata),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .out_status_o(rsp_o.status),
    .out_frame_o (rsp_o.frame_out)
  );

endmodule

>>> rtl/core/pffl_checker.sv
// Port-level checks for the physical frame free list unit, with bind.
// Depends on pffl_pkg and physical_frame_free_list_unit.
module pffl_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid_i,
  input logic                         req_ready_i,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic                         rsp_status_i,
  input logic [pffl_pkg::FRAME_W-1:0] rsp_frame_out_i
);
  import pffl_pkg::*;

  // one request at a time: ready drops after a request is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("request ready stayed high after a request");

  // a failed allocate never hands out a frame
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && (rsp_status_i == STATUS_EMPTY)) |-> (rsp_frame_out_i == '0))
    else $error("empty status with nonzero frame");

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> rsp_valid_i)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> ($stable(rsp_status_i) && $stable(rsp_frame_out_i)))
    else $error("response payload changed while stalled");

endmodule

bind physical_frame_free_list_unit pffl_checker u_pffl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_status_i   (rsp_o.status),
  .rsp_frame_out_i(rsp_o.frame_out)
);
